### hw/rtl/assert_macros.svh
// assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define SFBT_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sfbt check failed");

// property checked through reset as well
`define SFBT_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("sfbt reset check failed");

`endif

### hw/rtl/sfbt_pkg.sv
// types and codes of the sorted free block table
package sfbt_pkg;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // read address select
  localparam logic [2:0] RD_LAST = 3'd0;
  localparam logic [2:0] RD_ZERO = 3'd1;
  localparam logic [2:0] RD_DEC  = 3'd2;
  localparam logic [2:0] RD_INC  = 3'd3;
  localparam logic [2:0] RD_INC2 = 3'd4;

  // walk pointer update
  localparam logic [2:0] CUR_HOLD = 3'd0;
  localparam logic [2:0] CUR_LAST = 3'd1;
  localparam logic [2:0] CUR_ZERO = 3'd2;
  localparam logic [2:0] CUR_DEC  = 3'd3;
  localparam logic [2:0] CUR_INC  = 3'd4;

  // write select: target index and data source
  localparam logic [1:0] WR_UP_OLD   = 2'd0;
  localparam logic [1:0] WR_UP_NEW   = 2'd1;
  localparam logic [1:0] WR_ZERO_NEW = 2'd2;
  localparam logic [1:0] WR_DOWN_OLD = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] hole_addr;
    logic [31:0] block_size;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_addr;
    logic [31:0] found_size;
  } out_item_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] len;
  } entry_t;

  typedef struct packed {
    logic       capture;
    logic [2:0] rd_sel;
    logic [2:0] cur_op;
    logic       wr_en;
    logic [1:0] wr_sel;
    logic       fill_inc;
    logic       fill_dec;
    logic       res_set;
    logic [1:0] res_status;
    logic       res_take;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       fill_zero;
    logic       full;
    logic       cur_zero;
    logic       cur_last;
    logic       shift_up;
    logic       match;
  } sts_t;

endpackage

### hw/rtl/sfbt_dp.sv
// datapath: entry memory, fill count, walk pointer and result registers
module sfbt_dp #(
  parameter int DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sfbt_pkg::in_item_t  in_data,
  input  sfbt_pkg::cmd_t      cmd,
  output sfbt_pkg::sts_t      sts,
  output sfbt_pkg::out_item_t out_data
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  sfbt_pkg::entry_t    mem [DEPTH];
  sfbt_pkg::entry_t    rdata_r;
  sfbt_pkg::in_item_t  req_r;
  sfbt_pkg::out_item_t res_r;
  sfbt_pkg::out_item_t out_r;
  sfbt_pkg::entry_t    new_entry;
  sfbt_pkg::entry_t    wdata;
  logic [CW-1:0]       fill_r, fill_nxt;
  logic [IW-1:0]       cur_r, cur_nxt;
  logic [IW-1:0]       raddr;
  logic [IW-1:0]       waddr;

  assign new_entry.addr = req_r.hole_addr;
  assign new_entry.len  = req_r.block_size;

  always_comb begin
    case (cmd.rd_sel)
      sfbt_pkg::RD_LAST: raddr = fill_r[IW-1:0] - IW'(1);
      sfbt_pkg::RD_ZERO: raddr = '0;
      sfbt_pkg::RD_DEC:  raddr = cur_r - IW'(1);
      sfbt_pkg::RD_INC:  raddr = cur_r + IW'(1);
      sfbt_pkg::RD_INC2: raddr = cur_r + IW'(2);
      default:           raddr = '0;
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      sfbt_pkg::WR_UP_OLD: begin
        waddr = cur_r + IW'(1);
        wdata = rdata_r;
      end
      sfbt_pkg::WR_UP_NEW: begin
        waddr = cur_r + IW'(1);
        wdata = new_entry;
      end
      sfbt_pkg::WR_ZERO_NEW: begin
        waddr = '0;
        wdata = new_entry;
      end
      default: begin
        waddr = cur_r;
        wdata = rdata_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_comb begin
    case (cmd.cur_op)
      sfbt_pkg::CUR_LAST: cur_nxt = fill_r[IW-1:0] - IW'(1);
      sfbt_pkg::CUR_ZERO: cur_nxt = '0;
      sfbt_pkg::CUR_DEC:  cur_nxt = cur_r - IW'(1);
      sfbt_pkg::CUR_INC:  cur_nxt = cur_r + IW'(1);
      default:            cur_nxt = cur_r;
    endcase
  end

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.fill_inc) begin
      fill_nxt = fill_r + CW'(1);
    end else if (cmd.fill_dec) begin
      fill_nxt = fill_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (cmd.capture) begin
      req_r <= in_data;
    end
    if (cmd.res_set) begin
      res_r.status     <= cmd.res_status;
      res_r.found_addr <= cmd.res_take ? rdata_r.addr : 32'd0;
      res_r.found_size <= cmd.res_take ? rdata_r.len : 32'd0;
    end
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  assign out_data      = out_r;
  assign sts.func      = req_r.func;
  assign sts.fill_zero = (fill_r == '0);
  assign sts.full      = (fill_r >= CW'(DEPTH));
  assign sts.cur_zero  = (cur_r == '0);
  assign sts.cur_last  = ((CW'(cur_r) + CW'(1)) == fill_r);
  assign sts.shift_up  = (rdata_r.len > req_r.block_size);
  // remove looks for the address, a query for the first size that fits
  assign sts.match     = (req_r.func == sfbt_pkg::FUNC_REMOVE) ?
                         (rdata_r.addr == req_r.hole_addr) :
                         (rdata_r.len >= req_r.block_size);

endmodule

### hw/rtl/sfbt_ctrl.sv
// controller: sequences insert, remove and query walks over the table
module sfbt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  sfbt_pkg::sts_t sts,
  output sfbt_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_INS_WALK = 3'd2;
  localparam logic [2:0] S_INS_PUT  = 3'd3;
  localparam logic [2:0] S_SEARCH   = 3'd4;
  localparam logic [2:0] S_RM_SHIFT = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.rd_sel     = sfbt_pkg::RD_ZERO;
    cmd.cur_op     = sfbt_pkg::CUR_HOLD;
    cmd.wr_sel     = sfbt_pkg::WR_UP_OLD;
    cmd.res_status = sfbt_pkg::ST_OK;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        cmd.res_set = 1'b1;
        case (sts.func)
          sfbt_pkg::FUNC_INSERT: begin
            if (sts.full) begin
              cmd.res_status = sfbt_pkg::ST_FULL;
            end else if (sts.fill_zero) begin
              cmd.wr_en    = 1'b1;
              cmd.wr_sel   = sfbt_pkg::WR_ZERO_NEW;
              cmd.fill_inc = 1'b1;
            end else begin
              cmd.res_set = 1'b0;
              cmd.rd_sel  = sfbt_pkg::RD_LAST;
              cmd.cur_op  = sfbt_pkg::CUR_LAST;
              state_nxt   = S_INS_WALK;
            end
          end
          sfbt_pkg::FUNC_REMOVE, sfbt_pkg::FUNC_QUERY: begin
            if (sts.fill_zero) begin
              cmd.res_status = sfbt_pkg::ST_NOT_FOUND;
            end else begin
              cmd.res_set = 1'b0;
              cmd.rd_sel  = sfbt_pkg::RD_ZERO;
              cmd.cur_op  = sfbt_pkg::CUR_ZERO;
              state_nxt   = S_SEARCH;
            end
          end
          default: begin
            cmd.res_status = sfbt_pkg::ST_NOT_FOUND;
          end
        endcase
      end
      S_INS_WALK: begin
        // walk down from the tail, moving larger entries up by one
        cmd.rd_sel = sfbt_pkg::RD_DEC;
        cmd.wr_en  = 1'b1;
        if (sts.shift_up) begin
          cmd.wr_sel = sfbt_pkg::WR_UP_OLD;
          if (sts.cur_zero) begin
            state_nxt = S_INS_PUT;
          end else begin
            cmd.cur_op = sfbt_pkg::CUR_DEC;
          end
        end else begin
          cmd.wr_sel   = sfbt_pkg::WR_UP_NEW;
          cmd.fill_inc = 1'b1;
          cmd.res_set  = 1'b1;
          state_nxt    = S_DONE;
        end
      end
      S_INS_PUT: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_sel   = sfbt_pkg::WR_ZERO_NEW;
        cmd.fill_inc = 1'b1;
        cmd.res_set  = 1'b1;
        state_nxt    = S_DONE;
      end
      S_SEARCH: begin
        cmd.rd_sel = sfbt_pkg::RD_INC;
        if (sts.match) begin
          if (sts.func == sfbt_pkg::FUNC_QUERY) begin
            cmd.res_set  = 1'b1;
            cmd.res_take = 1'b1;
            state_nxt    = S_DONE;
          end else begin
            state_nxt = S_RM_SHIFT;
          end
        end else if (sts.cur_last) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = sfbt_pkg::ST_NOT_FOUND;
          state_nxt      = S_DONE;
        end else begin
          cmd.cur_op = sfbt_pkg::CUR_INC;
        end
      end
      S_RM_SHIFT: begin
        // close the gap: entry above the pointer moves down
        cmd.rd_sel = sfbt_pkg::RD_INC2;
        if (sts.cur_last) begin
          cmd.fill_dec = 1'b1;
          cmd.res_set  = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = sfbt_pkg::WR_DOWN_OLD;
          cmd.cur_op = sfbt_pkg::CUR_INC;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hw/rtl/sorted_free_block_table_top.sv
// Size-sorted free block table with first-fit lookup, one operation per beat.
// Decode answers an empty or full table or an unused code; a query walks up from
// index 0 to the fitting entry, a miss walks every entry, an insert walks down over
// the entries larger than the block, and a remove hit walks up to the entry and
// shifts the rest down; one entry read per cycle. A new beat is taken as out_valid
// rises. Reset clears the fill count and control only; table memory is not swept.
module sorted_free_block_table_top #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sfbt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sfbt_pkg::out_item_t out_data
);

  sfbt_pkg::cmd_t cmd;
  sfbt_pkg::sts_t sts;

  sfbt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  sfbt_dp #(
    .DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

### hw/rtl/sfbt_chk.sv
// port checker for the sorted free block table, bound to the top level
`include "assert_macros.svh"

module sfbt_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input sfbt_pkg::out_item_t out_data
);

  logic found_zero;

  assign found_zero = (out_data.found_addr == 32'd0) && (out_data.found_size == 32'd0);

  // a stalled result beat stays up and holds
  `SFBT_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data))
  // one operation at a time: input stalls right after a beat is taken
  `SFBT_ASSERT(a_in_one, in_valid && !in_stall |=> in_stall)
  // failed operations carry no entry
  `SFBT_ASSERT(a_zero_miss, out_valid && (out_data.status != sfbt_pkg::ST_OK) |-> found_zero)
  // no result beat right after reset
  `SFBT_ASSERT_RST(a_rst_quiet, !rst_n |=> !out_valid)

endmodule

bind sorted_free_block_table_top sfbt_chk u_sfbt_chk (.*);
